>>> rtl/core/keypoint_nms_list_unit_macros.svh
// Assertion macros shared by the checker of the keypoint list unit.
// Each macro expects clk and arst_n in scope.
`ifndef KEYPOINT_NMS_LIST_UNIT_MACROS_SVH
`define KEYPOINT_NMS_LIST_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPNMS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KPNMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/kpnms_pkg.sv
package kpnms_pkg;

	// Fixed field widths of the request and result channels
	localparam int RESP_W      = 8;
	localparam int IN_COORD_W  = 10;
	localparam int OUT_IDX_W   = 6;
	localparam int DIAM_W      = 5;
	localparam int DIAM_SQ_W   = 2 * DIAM_W;
	localparam int OP_W        = 2;

	// Configuration port
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam logic [RESP_W-1:0] MIN_RESPONSE_RST = 8'd100;
	localparam logic [DIAM_W-1:0] KEY_DIAMETER_RST = 5'd6;

	// Queue between front and back, depth is a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	typedef enum logic {
		REG_MIN_RESPONSE = 1'b0,
		REG_KEY_DIAMETER = 1'b1
	} reg_idx_t;

	// Request class decided by the front
	typedef enum logic [OP_W-1:0] {
		OP_BELOW = 2'd0,
		OP_CAND  = 2'd1,
		OP_EOF   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_BELOW      = 3'd0,
		ST_APPENDED   = 3'd1,
		ST_REPLACED   = 3'd2,
		ST_SUPPRESSED = 3'd3,
		ST_DROPPED    = 3'd4,
		ST_LIST       = 3'd5,
		ST_EMPTY      = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_LREAD,
		BK_LDATA,
		BK_EMIT
	} bk_state_t;

endpackage

>>> rtl/core/kpnms_front.sv
module kpnms_front #(
	parameter int COORD_BITS = 10,
	localparam int ITEM_W = kpnms_pkg::OP_W + 2 * COORD_BITS + kpnms_pkg::RESP_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [kpnms_pkg::RESP_W-1:0]     min_response,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [kpnms_pkg::IN_COORD_W-1:0] pix_x,
	input  logic [kpnms_pkg::IN_COORD_W-1:0] pix_y,
	input  logic [kpnms_pkg::RESP_W-1:0]     pix_response,
	output logic                            push_valid,
	input  logic                            push_ready,
	output logic [ITEM_W-1:0]               push_data
);

	logic                 vld_s1;
	logic [ITEM_W-1:0]    item_s1;
	logic                 accept;
	kpnms_pkg::op_t       op;
	logic [COORD_BITS-1:0] x_m;
	logic [COORD_BITS-1:0] y_m;

	// Take a new request whenever the stage is empty or drains this cycle
	assign in_ready = !vld_s1 || push_ready;
	assign accept   = in_valid && in_ready;

	// Classify and mask coordinates to the stored width
	always_comb begin
		x_m = COORD_BITS'({{COORD_BITS{1'b0}}, pix_x});
		y_m = COORD_BITS'({{COORD_BITS{1'b0}}, pix_y});
		if (kind) begin
			op = kpnms_pkg::OP_EOF;
		end else if (pix_response > min_response) begin
			op = kpnms_pkg::OP_CAND;
		end else begin
			op = kpnms_pkg::OP_BELOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= {op, x_m, y_m, pix_response};
		end
	end

	assign push_valid = vld_s1;
	assign push_data  = item_s1;

endmodule

>>> rtl/core/kpnms_queue.sv
module kpnms_queue #(
	parameter int WIDTH = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0]             slots_q [kpnms_pkg::QUEUE_DEPTH];
	logic [kpnms_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [kpnms_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [kpnms_pkg::QPTR_W:0]   fill_q;
	logic                         push;
	logic                         pop;

	assign push_ready = fill_q != (kpnms_pkg::QPTR_W + 1)'(kpnms_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slots_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/kpnms_back.sv
module kpnms_back #(
	parameter int MAX_KEYS   = 64,
	parameter int COORD_BITS = 10,
	localparam int ITEM_W = kpnms_pkg::OP_W + 2 * COORD_BITS + kpnms_pkg::RESP_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [kpnms_pkg::DIAM_W-1:0]     key_diameter,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  logic [ITEM_W-1:0]               q_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      status,
	output logic [kpnms_pkg::OUT_IDX_W-1:0]  key_index,
	output logic [kpnms_pkg::IN_COORD_W-1:0] key_x,
	output logic [kpnms_pkg::IN_COORD_W-1:0] key_y,
	output logic [kpnms_pkg::RESP_W-1:0]     key_response,
	output logic                            overflowed,
	output logic                            last
);

	localparam int CW      = COORD_BITS;
	localparam int RW      = kpnms_pkg::RESP_W;
	localparam int IDX_W   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNT_W   = $clog2(MAX_KEYS + 1);
	localparam int ENTRY_W = 2 * CW + RW;
	localparam int SQ_W    = 2 * CW;
	localparam int SUM_W   = 2 * CW + 1;
	localparam int CMP_W   = (SUM_W > kpnms_pkg::DIAM_SQ_W) ? SUM_W : kpnms_pkg::DIAM_SQ_W;
	localparam int OIW     = kpnms_pkg::OUT_IDX_W;
	localparam int OCW     = kpnms_pkg::IN_COORD_W;

	// Keypoint list memory: {x, y, response}
	logic [ENTRY_W-1:0] list_mem [MAX_KEYS];

	kpnms_pkg::bk_state_t state_q, state_d;

	// Request fields at the head of the queue
	kpnms_pkg::op_t q_op;
	logic [CW-1:0]  q_x;
	logic [CW-1:0]  q_y;
	logic [RW-1:0]  q_r;

	// Current request
	logic [CW-1:0]  cur_x_q;
	logic [CW-1:0]  cur_y_q;
	logic [RW-1:0]  cur_r_q;

	logic [CNT_W-1:0] count_q;
	logic             flag_q;
	logic [CNT_W-1:0] issue_q;
	logic [kpnms_pkg::DIAM_SQ_W-1:0] d2_q;

	// Scan pipeline
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [ENTRY_W-1:0] rdata_s1;
	logic               vld_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [SQ_W-1:0]    dx2_s2;
	logic [SQ_W-1:0]    dy2_s2;
	logic [RW-1:0]      resp_s2;

	logic               overlap_q;
	logic [IDX_W-1:0]   first_q;
	kpnms_pkg::status_t res_status_q;
	logic [IDX_W-1:0]   res_idx_q;

	// Output register
	logic               out_valid_q;
	kpnms_pkg::status_t out_status_q;
	logic [OIW-1:0]     out_idx_q;
	logic [OCW-1:0]     out_x_q;
	logic [OCW-1:0]     out_y_q;
	logic [RW-1:0]      out_r_q;
	logic               out_ovf_q;
	logic               out_last_q;

	// Control
	logic               out_free;
	logic               pop;
	logic               issue;
	logic               hit;
	logic               rep;
	logic               scan_done;
	logic               list_last;
	logic               load_list;
	logic               load_res;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [CW-1:0]      e_x;
	logic [CW-1:0]      e_y;
	logic [RW-1:0]      e_r;
	logic [CW-1:0]      dx;
	logic [CW-1:0]      dy;
	logic [SUM_W-1:0]   dist2;
	logic               full;

	assign q_op = kpnms_pkg::op_t'(q_item[ITEM_W-1 -: kpnms_pkg::OP_W]);
	assign q_x  = q_item[2*CW+RW-1 -: CW];
	assign q_y  = q_item[CW+RW-1 -: CW];
	assign q_r  = q_item[RW-1:0];

	assign e_x = rdata_s1[ENTRY_W-1 -: CW];
	assign e_y = rdata_s1[CW+RW-1 -: CW];
	assign e_r = rdata_s1[RW-1:0];

	assign full      = count_q == CNT_W'(MAX_KEYS);
	assign out_free  = !out_valid_q || out_ready;
	assign dist2     = SUM_W'(dx2_s2) + SUM_W'(dy2_s2);
	assign hit       = vld_s2 && (CMP_W'(dist2) < CMP_W'(d2_q));
	assign list_last = (issue_q + CNT_W'(1)) == count_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kpnms_pkg::BK_IDLE: begin
				if (q_valid) begin
					unique case (q_op)
						kpnms_pkg::OP_CAND: state_d = kpnms_pkg::BK_SCAN;
						kpnms_pkg::OP_EOF: begin
							state_d = (count_q == '0) ? kpnms_pkg::BK_EMIT : kpnms_pkg::BK_LREAD;
						end
						default: state_d = kpnms_pkg::BK_EMIT;
					endcase
				end
			end
			kpnms_pkg::BK_SCAN: begin
				if (rep || scan_done) begin
					state_d = kpnms_pkg::BK_EMIT;
				end
			end
			kpnms_pkg::BK_LREAD: state_d = kpnms_pkg::BK_LDATA;
			kpnms_pkg::BK_LDATA: begin
				if (out_free) begin
					state_d = list_last ? kpnms_pkg::BK_IDLE : kpnms_pkg::BK_LREAD;
				end
			end
			kpnms_pkg::BK_EMIT: begin
				if (out_free) begin
					state_d = kpnms_pkg::BK_IDLE;
				end
			end
			default: state_d = kpnms_pkg::BK_IDLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		q_ready   = state_q == kpnms_pkg::BK_IDLE;
		pop       = q_ready && q_valid;
		rep       = (state_q == kpnms_pkg::BK_SCAN) && hit && (cur_r_q > resp_s2);
		issue     = (state_q == kpnms_pkg::BK_SCAN) && !rep && (issue_q != count_q);
		scan_done = (state_q == kpnms_pkg::BK_SCAN) && (issue_q == count_q)
			&& !rd_vld_s1 && !vld_s2;
		load_list = (state_q == kpnms_pkg::BK_LDATA) && out_free;
		load_res  = (state_q == kpnms_pkg::BK_EMIT) && out_free;
		mem_we    = rep || (scan_done && !overlap_q && !full);
		mem_waddr = rep ? idx_s2 : count_q[IDX_W-1:0];
	end

	// Distance terms against the entry just read
	always_comb begin
		dx = (cur_x_q > e_x) ? cur_x_q - e_x : e_x - cur_x_q;
		dy = (cur_y_q > e_y) ? cur_y_q - e_y : e_y - cur_y_q;
	end

	// Sequencer, list bookkeeping and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kpnms_pkg::BK_IDLE;
			count_q     <= '0;
			flag_q      <= 1'b0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			vld_s2      <= 1'b0;
			overlap_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			vld_s2    <= rd_vld_s1 && (state_q == kpnms_pkg::BK_SCAN) && !rep;

			if (pop) begin
				issue_q   <= '0;
				overlap_q <= 1'b0;
			end else if (issue) begin
				issue_q <= issue_q + CNT_W'(1);
			end else if (load_list && !list_last) begin
				issue_q <= issue_q + CNT_W'(1);
			end

			if (hit && (state_q == kpnms_pkg::BK_SCAN)) begin
				overlap_q <= 1'b1;
			end

			// Append or drop once the scan found no overlap
			if (scan_done && !overlap_q) begin
				if (full) begin
					flag_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end

			// Clear the list after the end-of-frame dump
			if ((load_list && list_last)
				|| (load_res && (res_status_q == kpnms_pkg::ST_EMPTY))) begin
				count_q <= '0;
				flag_q  <= 1'b0;
			end

			if (load_list || load_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// List memory, registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			list_mem[mem_waddr] <= {cur_x_q, cur_y_q, cur_r_q};
		end
		rdata_s1 <= list_mem[issue_q[IDX_W-1:0]];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		d2_q      <= kpnms_pkg::DIAM_SQ_W'(key_diameter) * kpnms_pkg::DIAM_SQ_W'(key_diameter);
		rd_idx_s1 <= issue_q[IDX_W-1:0];
		idx_s2    <= rd_idx_s1;
		dx2_s2    <= SQ_W'(dx) * SQ_W'(dx);
		dy2_s2    <= SQ_W'(dy) * SQ_W'(dy);
		resp_s2   <= e_r;

		if (pop) begin
			cur_x_q <= q_x;
			cur_y_q <= q_y;
			cur_r_q <= q_r;
			if (q_op == kpnms_pkg::OP_EOF) begin
				res_status_q <= kpnms_pkg::ST_EMPTY;
			end else begin
				res_status_q <= kpnms_pkg::ST_BELOW;
			end
			res_idx_q <= '0;
		end

		// Remember the first overlapping entry
		if (hit && !overlap_q && (state_q == kpnms_pkg::BK_SCAN)) begin
			first_q <= idx_s2;
		end

		if (rep) begin
			res_status_q <= kpnms_pkg::ST_REPLACED;
			res_idx_q    <= idx_s2;
		end else if (scan_done) begin
			if (overlap_q) begin
				res_status_q <= kpnms_pkg::ST_SUPPRESSED;
				res_idx_q    <= first_q;
			end else if (full) begin
				res_status_q <= kpnms_pkg::ST_DROPPED;
				res_idx_q    <= '0;
			end else begin
				res_status_q <= kpnms_pkg::ST_APPENDED;
				res_idx_q    <= count_q[IDX_W-1:0];
			end
		end

		if (load_list) begin
			out_status_q <= kpnms_pkg::ST_LIST;
			out_idx_q    <= OIW'({{OIW{1'b0}}, issue_q});
			out_x_q      <= OCW'({{OCW{1'b0}}, e_x});
			out_y_q      <= OCW'({{OCW{1'b0}}, e_y});
			out_r_q      <= e_r;
			out_ovf_q    <= flag_q;
			out_last_q   <= list_last;
		end else if (load_res) begin
			out_status_q <= res_status_q;
			out_idx_q    <= OIW'({{OIW{1'b0}}, res_idx_q});
			out_ovf_q    <= flag_q;
			out_last_q   <= 1'b1;
			if (res_status_q == kpnms_pkg::ST_EMPTY) begin
				out_x_q <= '0;
				out_y_q <= '0;
				out_r_q <= '0;
			end else begin
				out_x_q <= OCW'({{OCW{1'b0}}, cur_x_q});
				out_y_q <= OCW'({{OCW{1'b0}}, cur_y_q});
				out_r_q <= cur_r_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign key_index    = out_idx_q;
	assign key_x        = out_x_q;
	assign key_y        = out_y_q;
	assign key_response = out_r_q;
	assign overflowed   = out_ovf_q;
	assign last         = out_last_q;

endmodule

>>> rtl/core/keypoint_nms_list_unit.sv
// Keypoint non-maximum suppression over a stored keypoint list.
// Request channel (in_valid/in_ready): kind, pix_x, pix_y, pix_response in raster
// order; kind high marks end of frame. Result channel (out_valid/out_ready):
// status, key_index, key_x, key_y, key_response, overflowed, last. A pixel
// request gives one result; an end-of-frame request dumps the list, one
// result per entry with last on the final one, then clears the list.
// Registers min_response and key_diameter sit on the APB port at 0x0 and 0x4.
// Timing: a request passes a front stage and a two-entry queue, then the back
// engine. A candidate scans the list one entry per cycle through the list
// memory's single read port. An end-of-frame dump reads each entry, then
// loads its result. Requests are handled one at a time by the back engine;
// the queue keeps taking requests while it scans. A stalled receiver holds
// the result register and the engine waits, so the queue fills and in_ready
// drops.
// Reset empties the list, clears the overflow flag, loads min_response = 100
// and key_diameter = 6. List contents are not cleared.
module keypoint_nms_list_unit #(
	parameter int MAX_KEYS   = 64,
	parameter int COORD_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [kpnms_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [kpnms_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [kpnms_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             kind,
	input  logic [kpnms_pkg::IN_COORD_W-1:0]  pix_x,
	input  logic [kpnms_pkg::IN_COORD_W-1:0]  pix_y,
	input  logic [kpnms_pkg::RESP_W-1:0]      pix_response,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       status,
	output logic [kpnms_pkg::OUT_IDX_W-1:0]   key_index,
	output logic [kpnms_pkg::IN_COORD_W-1:0]  key_x,
	output logic [kpnms_pkg::IN_COORD_W-1:0]  key_y,
	output logic [kpnms_pkg::RESP_W-1:0]      key_response,
	output logic                             overflowed,
	output logic                             last
);

	localparam int ITEM_W = kpnms_pkg::OP_W + 2 * COORD_BITS + kpnms_pkg::RESP_W;
	localparam int DW     = kpnms_pkg::APB_DATA_W;

	logic [kpnms_pkg::RESP_W-1:0] min_response_q;
	logic [kpnms_pkg::DIAM_W-1:0] key_diameter_q;
	logic                         cfg_we;
	kpnms_pkg::reg_idx_t          reg_sel;

	logic              push_valid;
	logic              push_ready;
	logic [ITEM_W-1:0] push_data;
	logic              pop_valid;
	logic              pop_ready;
	logic [ITEM_W-1:0] pop_data;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign reg_sel = kpnms_pkg::reg_idx_t'(paddr[2]);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_response_q <= kpnms_pkg::MIN_RESPONSE_RST;
			key_diameter_q <= kpnms_pkg::KEY_DIAMETER_RST;
		end else if (cfg_we) begin
			unique case (reg_sel)
				kpnms_pkg::REG_MIN_RESPONSE: min_response_q <= pwdata[kpnms_pkg::RESP_W-1:0];
				kpnms_pkg::REG_KEY_DIAMETER: key_diameter_q <= pwdata[kpnms_pkg::DIAM_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (reg_sel)
			kpnms_pkg::REG_MIN_RESPONSE: prdata = DW'(min_response_q);
			kpnms_pkg::REG_KEY_DIAMETER: prdata = DW'(key_diameter_q);
			default:                     prdata = '0;
		endcase
	end

	kpnms_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.min_response (min_response_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.pix_x        (pix_x),
		.pix_y        (pix_y),
		.pix_response (pix_response),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	kpnms_queue #(
		.WIDTH (ITEM_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	kpnms_back #(
		.MAX_KEYS   (MAX_KEYS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_diameter (key_diameter_q),
		.q_valid      (pop_valid),
		.q_ready      (pop_ready),
		.q_item       (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.key_index    (key_index),
		.key_x        (key_x),
		.key_y        (key_y),
		.key_response (key_response),
		.overflowed   (overflowed),
		.last         (last)
	);

endmodule

>>> rtl/core/kpnms_checker.sv
`include "keypoint_nms_list_unit_macros.svh"

module kpnms_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [2:0]                       status,
	input logic [kpnms_pkg::OUT_IDX_W-1:0]   key_index,
	input logic [kpnms_pkg::IN_COORD_W-1:0]  key_x,
	input logic [kpnms_pkg::IN_COORD_W-1:0]  key_y,
	input logic [kpnms_pkg::RESP_W-1:0]      key_response,
	input logic                             overflowed,
	input logic                             last
);

	// A stalled result holds its payload
	`KPNMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(key_index) && $stable(key_x)
		&& $stable(last), "result changed while stalled")

	// Only list dumps may carry more than one result per request
	`KPNMS_ASSERT_SAME(a_pixel_last, out_valid && (status != kpnms_pkg::ST_LIST), last,
		"single result without last")

	// A dropped candidate raises the overflow flag and reports slot zero
	`KPNMS_ASSERT_SAME(a_drop_flag, out_valid && (status == kpnms_pkg::ST_DROPPED),
		overflowed && (key_index == '0), "drop without overflow")

	// An empty list reports a zero keypoint
	`KPNMS_ASSERT_SAME(a_empty_zero, out_valid && (status == kpnms_pkg::ST_EMPTY),
		(key_x == '0) && (key_y == '0) && (key_response == '0),
		"empty list with nonzero keypoint")

endmodule

bind keypoint_nms_list_unit kpnms_checker u_kpnms_checker (.*);
